FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the transport stream packetizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hw/rtl/tsp_pkg.sv
package tsp_pkg;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PID     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd2;

	localparam logic [7:0] TS_SYNC       = 8'h47;
	localparam logic [7:0] TS_FLAGS_BASE = 8'h20;
	localparam logic [7:0] TS_START      = 8'h40;
	localparam logic [7:0] TS_CC_BASE    = 8'h10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// Output positions of one job, in emission order.
	localparam int NUM_POS   = 9;
	localparam int POS_SYNC  = 0;
	localparam int POS_FLAGS = 1;
	localparam int POS_PID   = 2;
	localparam int POS_CC    = 3;
	localparam int POS_PTR   = 4;
	localparam int POS_HELD0 = 5;
	localparam int POS_HELD1 = 6;
	localparam int POS_DATA  = 7;
	localparam int POS_FILL  = 8;

	typedef struct packed {
		logic [NUM_POS-1:0] mask;
		logic [7:0]         flags_byte;
		logic [7:0]         pid_byte;
		logic [7:0]         cc_byte;
		logic [7:0]         held0;
		logic [7:0]         held1;
		logic [7:0]         data;
		logic               pend;
		logic [7:0]         fill;
	} job_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} queue_ctl_t;

endpackage

FILE: hw/rtl/tsp_front.sv
module tsp_front #(
	parameter int PAYLOAD_BYTES = 184
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          accept,
	input  logic [7:0]                    data_byte,
	input  logic                          buffer_end,
	output logic                          push,
	output tsp_pkg::job_t                 job
);

	localparam int CW = $clog2(PAYLOAD_BYTES + 1);

	logic [12:0]   pid_q;
	logic          section_q;
	logic          enable_q;
	logic [CW-1:0] chunk_q;
	logic [7:0]    held0_q;
	logic [7:0]    held1_q;
	logic [1:0]    held_cnt_q;
	logic [3:0]    cc_q;
	logic          buffer_first_q;
	logic          header_sent_q;

	logic          hdr;
	logic          hold;
	logic          flag;
	logic          ptr;
	logic [CW-1:0] base;
	logic [CW-1:0] chunk_new;
	logic          pend;
	logic [7:0]    fill;

	always_comb begin
		hdr  = !header_sent_q;
		hold = hdr && !section_q && (held_cnt_q != 2'd2) && !buffer_end;
		if (section_q) begin
			flag = buffer_first_q && (held_cnt_q == 2'd0);
		end else begin
			flag = (held_cnt_q == 2'd2) && (held0_q == 8'h00) && (held1_q == 8'h00)
				&& (data_byte == 8'h01);
		end
		ptr       = hdr && section_q && flag;
		base      = CW'(ptr) + CW'(held_cnt_q);
		chunk_new = (hdr ? base : chunk_q) + CW'(1);
		pend      = chunk_new >= CW'(PAYLOAD_BYTES);
		fill      = (buffer_end && !pend) ? 8'(CW'(PAYLOAD_BYTES) - chunk_new) : 8'h00;
	end

	always_comb begin
		push                      = accept && enable_q && !hold;
		job.mask                  = '0;
		job.mask[tsp_pkg::POS_SYNC]  = hdr;
		job.mask[tsp_pkg::POS_FLAGS] = hdr;
		job.mask[tsp_pkg::POS_PID]   = hdr;
		job.mask[tsp_pkg::POS_CC]    = hdr;
		job.mask[tsp_pkg::POS_PTR]   = ptr;
		job.mask[tsp_pkg::POS_HELD0] = hdr && (held_cnt_q != 2'd0);
		job.mask[tsp_pkg::POS_HELD1] = hdr && (held_cnt_q == 2'd2);
		job.mask[tsp_pkg::POS_DATA]  = 1'b1;
		job.mask[tsp_pkg::POS_FILL]  = fill != 8'h00;
		job.flags_byte = tsp_pkg::TS_FLAGS_BASE | (flag ? tsp_pkg::TS_START : 8'h00)
			| {3'b000, pid_q[12:8]};
		job.pid_byte   = pid_q[7:0];
		job.cc_byte    = tsp_pkg::TS_CC_BASE | {4'h0, cc_q};
		job.held0      = held0_q;
		job.held1      = held1_q;
		job.data       = data_byte;
		job.pend       = pend;
		job.fill       = fill;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_q          <= '0;
			section_q      <= 1'b0;
			enable_q       <= 1'b0;
			chunk_q        <= '0;
			held_cnt_q     <= '0;
			cc_q           <= '0;
			buffer_first_q <= 1'b1;
			header_sent_q  <= 1'b0;
		end else begin
			if (accept && enable_q) begin
				if (hold) begin
					held_cnt_q     <= held_cnt_q + 2'd1;
					buffer_first_q <= 1'b0;
				end else begin
					if (hdr) begin
						cc_q <= cc_q + 4'd1;
					end
					held_cnt_q <= '0;
					if (buffer_end) begin
						chunk_q        <= '0;
						header_sent_q  <= 1'b0;
						buffer_first_q <= 1'b1;
					end else begin
						chunk_q        <= pend ? '0 : chunk_new;
						header_sent_q  <= !pend;
						buffer_first_q <= 1'b0;
					end
				end
			end
			if (cfg_we) begin
				unique case (cfg_index)
					tsp_pkg::CFG_PID: begin
						pid_q <= cfg_data[12:0];
					end
					tsp_pkg::CFG_SECTION: begin
						section_q <= cfg_data[0];
					end
					tsp_pkg::CFG_ENABLE: begin
						enable_q <= cfg_data[0];
						if (cfg_data[0] && !enable_q) begin
							cc_q           <= '0;
							chunk_q        <= '0;
							held_cnt_q     <= '0;
							header_sent_q  <= 1'b0;
							buffer_first_q <= 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && enable_q && hold) begin
			if (held_cnt_q[0]) begin
				held1_q <= data_byte;
			end else begin
				held0_q <= data_byte;
			end
		end
	end

endmodule

FILE: hw/rtl/tsp_queue.sv
module tsp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  pop,
	input  tsp_pkg::job_t         wr_job,
	output tsp_pkg::job_t         head,
	output tsp_pkg::queue_ctl_t   ctl
);

	tsp_pkg::job_t                    entries_q [tsp_pkg::QUEUE_DEPTH];
	logic [tsp_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [tsp_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [tsp_pkg::QUEUE_AW:0]       count_q;

	always_comb begin
		head      = entries_q[rd_ptr_q];
		ctl.push  = push;
		ctl.pop   = pop;
		ctl.full  = count_q == (tsp_pkg::QUEUE_AW + 1)'(tsp_pkg::QUEUE_DEPTH);
		ctl.empty = count_q == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

FILE: hw/rtl/tsp_back.sv
module tsp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  tsp_pkg::job_t head,
	input  logic          head_valid,
	output logic          pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,
	output logic          m_tlast,
	output logic          m_tuser
);

	logic                        active_q;
	logic [tsp_pkg::NUM_POS-1:0] rem_q;
	logic                        m_tvalid_q;
	logic [15:0]                 m_tdata_q;
	logic                        m_tlast_q;
	logic                        m_tuser_q;

	logic [tsp_pkg::NUM_POS-1:0] cur;
	logic [tsp_pkg::NUM_POS-1:0] low;
	logic [tsp_pkg::NUM_POS-1:0] next_rem;
	logic                        load;
	logic                        emit;
	logic [7:0]                  byte_val;
	logic [7:0]                  fill_val;
	logic                        pend_val;

	always_comb begin
		cur      = active_q ? rem_q : head.mask;
		low      = cur & (~cur + 1'b1);
		next_rem = cur & ~low;
		load     = !m_tvalid_q || m_tready;
		emit     = load && head_valid;
		pop      = emit && (next_rem == '0);
	end

	always_comb begin
		byte_val = 8'h00;
		fill_val = 8'h00;
		pend_val = 1'b0;
		if (low[tsp_pkg::POS_SYNC]) begin
			byte_val = tsp_pkg::TS_SYNC;
		end else if (low[tsp_pkg::POS_FLAGS]) begin
			byte_val = head.flags_byte;
		end else if (low[tsp_pkg::POS_PID]) begin
			byte_val = head.pid_byte;
		end else if (low[tsp_pkg::POS_CC]) begin
			byte_val = head.cc_byte;
		end else if (low[tsp_pkg::POS_HELD0]) begin
			byte_val = head.held0;
		end else if (low[tsp_pkg::POS_HELD1]) begin
			byte_val = head.held1;
		end else if (low[tsp_pkg::POS_DATA]) begin
			byte_val = head.data;
			pend_val = head.pend;
		end else if (low[tsp_pkg::POS_FILL]) begin
			fill_val = head.fill;
			pend_val = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			rem_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= emit;
			end
			if (emit) begin
				active_q <= next_rem != '0;
				rem_q    <= next_rem;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {fill_val, byte_val};
			m_tlast_q <= pend_val;
			m_tuser_q <= next_rem == '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: hw/rtl/ts_packetizer.sv
// Transport stream packetizer. Payload bytes arrive one per transaction on the
// slave side and leave as 188-byte packets (header, optional pointer byte,
// payload, zero fill) on the master side, one output transaction per cycle
// while m_tready is high. The front end takes one input byte per cycle while
// its four-entry job queue has room; each byte yields zero to eight output
// transactions. The back-end sequencer emits one transaction per cycle while
// m_tready is high and the queue is not empty. A zero-fill transaction stands
// for the whole padding run. An input byte passes the job queue and the output
// register before it leaves. No clearing pass after reset; configuration
// writes take effect at once and must arrive while idle.
`include "assert_macros.svh"

module ts_packetizer #(
	parameter int PAYLOAD_BYTES = 184
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tsp_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] data_byte
	input  logic                          s_tlast,   // buffer_end
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [7:0] out_byte, [15:8] zero_fill
	output logic                          m_tlast,   // packet_end
	output logic                          m_tuser    // run_last
);

	logic                accept;
	logic                push;
	logic                pop;
	tsp_pkg::job_t       wr_job;
	tsp_pkg::job_t       head;
	tsp_pkg::queue_ctl_t q_ctl;
	logic                fill_item;
	logic                fill_tail;

	assign s_tready = !q_ctl.full;
	assign accept   = s_tvalid && s_tready;

	tsp_front #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (s_tdata),
		.buffer_end (s_tlast),
		.push       (push),
		.job        (wr_job)
	);

	tsp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.wr_job (wr_job),
		.head   (head),
		.ctl    (q_ctl)
	);

	tsp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_ctl.empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

	assign fill_item = m_tvalid && (m_tdata[15:8] != 8'h00);
	assign fill_tail = m_tlast && m_tuser && (m_tdata[7:0] == 8'h00);

	`ASSERT_NEVER(a_push_full, clk, arst_n, q_ctl.push && q_ctl.full)
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, q_ctl.pop && q_ctl.empty)
	`ASSERT_PROP(a_fill_ends_run, clk, arst_n, fill_item |-> fill_tail)

endmodule
